// File: sv/erm_pkg.sv
package erm_pkg;

  localparam int GROUP_SIZE = 5;
  localparam int DIST_W     = 13;
  localparam int WIDTH_W    = 15;
  localparam int FACTOR_W   = 4;
  localparam int CONFIRM_W  = 3;
  localparam int CNT_W      = $clog2(GROUP_SIZE + 1);
  localparam int IDX_W      = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int POS_W      = IDX_W;
  localparam int SUM_W      = DIST_W + CNT_W;
  localparam int PROD_W     = FACTOR_W + SUM_W;
  localparam int CONV_W     = WIDTH_W + 15;
  localparam int CONV_SHIFT = 16;
  localparam int CDIST_W    = CONV_W - CONV_SHIFT;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W  = 3;

  localparam logic [14:0] CONV_FACTOR = 15'd17984;

  localparam logic [DIST_W-1:0]    MIN_DIST_RST = DIST_W'(32);
  localparam logic [DIST_W-1:0]    MAX_DIST_RST = DIST_W'(5600);
  localparam logic [DIST_W-1:0]    NOISE_RST    = DIST_W'(320);
  localparam logic [FACTOR_W-1:0]  FACTOR_RST   = FACTOR_W'(3);
  localparam logic [CONFIRM_W-1:0] CONFIRM_RST  = CONFIRM_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DIST = 3'd0,
    REG_MAX_DIST = 3'd1,
    REG_NOISE    = 3'd2,
    REG_FACTOR   = 3'd3,
    REG_CONFIRM  = 3'd4
  } erm_reg_t;

  typedef struct packed {
    logic [DIST_W-1:0]    min_distance;
    logic [DIST_W-1:0]    max_distance;
    logic [DIST_W-1:0]    noise_limit;
    logic [FACTOR_W-1:0]  outlier_factor;
    logic [CONFIRM_W-1:0] confirm_needed;
  } erm_cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] sample;
    logic              keep;
    logic              last;
  } erm_word_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SORT,
    ST_MEDIAN,
    ST_DEV,
    ST_DECIDE
  } erm_state_t;

endpackage

// File: sv/erm_front.sv
module erm_front
  import erm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [WIDTH_W-1:0]  echo_width,
  input  logic                timed_out,
  input  erm_cfg_t            cfg,
  input  logic                q_full,
  output logic                push,
  output erm_word_t           push_word
);

  logic [POS_W-1:0]   pos;
  logic [CONV_W-1:0]  prod;
  logic [CDIST_W-1:0] dist_full;

  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign prod      = CONV_W'(echo_width) * CONV_W'(CONV_FACTOR);
  assign dist_full = timed_out ? '0 : prod[CONV_W-1:CONV_SHIFT];

  always_comb begin
    push_word.sample = dist_full[DIST_W-1:0];
    push_word.keep   = (dist_full > CDIST_W'(cfg.min_distance)) &&
                       (dist_full < CDIST_W'(cfg.max_distance));
    push_word.last   = (pos == POS_W'(GROUP_SIZE - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push) begin
      pos <= push_word.last ? '0 : pos + POS_W'(1);
    end
  end

endmodule

// File: sv/erm_queue.sv
module erm_queue
  import erm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  erm_word_t push_word,
  output logic      full,
  input  logic      pop,
  output erm_word_t pop_word,
  output logic      empty
);

  erm_word_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

// File: sv/erm_back.sv
module erm_back
  import erm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  erm_cfg_t              cfg,
  input  logic                  empty,
  input  erm_word_t             pop_word,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIST_W-1:0]     distance,
  output logic                  held,
  output logic [CNT_W-1:0]      kept_count
);

  erm_state_t        state, state_next;
  logic [DIST_W-1:0] s [GROUP_SIZE];
  logic [DIST_W-1:0] s_swap [GROUP_SIZE];
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_after;
  logic [IDX_W-1:0]  phase;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [DIST_W-1:0] rd_data;
  logic [DIST_W-1:0] med;
  logic [DIST_W-1:0] absdev;
  logic [SUM_W-1:0]  dev_sum;
  logic [DIST_W-1:0] last_distance;
  logic [CONFIRM_W-1:0] jump_count;
  logic [CONFIRM_W-1:0] jc_inc;
  logic [DIST_W-1:0] diff;
  logic [SUM_W-1:0]  lhs;
  logic [PROD_W-1:0] rhs;
  logic [SUM_W-1:0]  noise_n;
  logic              jump;
  logic              go;

  assign cnt_after = cnt + CNT_W'(pop_word.keep);
  assign rd_idx    = (state == ST_MEDIAN) ? IDX_W'(cnt >> 1) : idx;
  assign rd_data   = s[rd_idx];
  assign absdev    = (rd_data > med) ? rd_data - med : med - rd_data;
  assign go        = (state == ST_DECIDE) && !(out_valid && out_stall);

  // one odd-even transposition phase
  always_comb begin
    for (int j = 0; j < GROUP_SIZE; j++) s_swap[j] = s[j];
    for (int j = 0; j < GROUP_SIZE - 1; j++) begin
      if ((j % 2) == int'(phase[0]) && s[j] > s[j+1]) begin
        s_swap[j]   = s[j+1];
        s_swap[j+1] = s[j];
      end
    end
  end

  always_comb begin
    diff    = (med > last_distance) ? med - last_distance : last_distance - med;
    lhs     = SUM_W'(diff) * SUM_W'(cnt);
    rhs     = PROD_W'(cfg.outlier_factor) * PROD_W'(dev_sum);
    noise_n = SUM_W'(cfg.noise_limit) * SUM_W'(cnt);
    jump    = (last_distance != '0) && (PROD_W'(lhs) > rhs) && (dev_sum < noise_n);
    jc_inc  = jump_count + CONFIRM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      ST_COLLECT: begin
        if (!empty) begin
          pop = 1'b1;
          if (pop_word.last) state_next = (cnt_after == '0) ? ST_DECIDE : ST_SORT;
        end
      end
      ST_SORT: begin
        if (phase == IDX_W'(GROUP_SIZE - 1)) state_next = ST_MEDIAN;
      end
      ST_MEDIAN: state_next = ST_DEV;
      ST_DEV: begin
        if (CNT_W'(idx) + CNT_W'(1) == cnt) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (go) state_next = ST_COLLECT;
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // sample store, no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (pop_word.keep && CNT_W'(j) == cnt) s[j] <= pop_word.sample;
        if (pop_word.last && CNT_W'(j) >= cnt_after) s[j] <= '1;
      end
    end else if (state == ST_SORT) begin
      for (int j = 0; j < GROUP_SIZE; j++) s[j] <= s_swap[j];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_word.last) begin
      phase   <= '0;
      idx     <= '0;
      dev_sum <= '0;
      med     <= '0;
    end else begin
      if (state == ST_SORT)   phase <= phase + IDX_W'(1);
      if (state == ST_MEDIAN) med <= rd_data;
      if (state == ST_DEV) begin
        dev_sum <= dev_sum + SUM_W'(absdev);
        idx     <= idx + IDX_W'(1);
      end
    end
    if (go) begin
      kept_count <= cnt;
      if (cnt == '0) begin
        distance <= '0;
        held     <= 1'b0;
      end else if (jump && jc_inc < cfg.confirm_needed) begin
        distance <= last_distance;
        held     <= 1'b1;
      end else begin
        distance <= med;
        held     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      last_distance <= '0;
      jump_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) cnt <= cnt_after;
      if (go) begin
        cnt       <= '0;
        out_valid <= 1'b1;
        if (cnt != '0) begin
          if (jump && jc_inc < cfg.confirm_needed) begin
            jump_count <= jc_inc;
          end else begin
            jump_count    <= '0;
            last_distance <= med;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/echo_range_median_filter.sv
// Group result: after the fifth word of the group is taken, the back end steps through
//   queue pop, 5 sort phases, median, n deviation steps (n = kept samples), decision.
//   With nothing kept it steps through queue pop, decision.
// Throughput: one word a cycle while the 4-word queue has room; the back end works on
//   one group at a time and pops no new word until the decision for the last group is
//   taken, which out_stall can hold.
// Reset (rst, synchronous): registers to defaults, counters and queue cleared;
//   the sample store is not reset.
module echo_range_median_filter
  import erm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WIDTH_W-1:0]   echo_width,
  input  logic                 timed_out,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DIST_W-1:0]    distance,
  output logic                 held,
  output logic [CNT_W-1:0]     kept_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data
);

  erm_cfg_t  cfg;
  logic      q_full;
  logic      q_empty;
  logic      push;
  logic      pop;
  erm_word_t push_word;
  erm_word_t pop_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_distance   <= MIN_DIST_RST;
      cfg.max_distance   <= MAX_DIST_RST;
      cfg.noise_limit    <= NOISE_RST;
      cfg.outlier_factor <= FACTOR_RST;
      cfg.confirm_needed <= CONFIRM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_DIST: cfg.min_distance   <= cfg_data;
        REG_MAX_DIST: cfg.max_distance   <= cfg_data;
        REG_NOISE:    cfg.noise_limit    <= cfg_data;
        REG_FACTOR:   cfg.outlier_factor <= cfg_data[FACTOR_W-1:0];
        REG_CONFIRM:  cfg.confirm_needed <= cfg_data[CONFIRM_W-1:0];
        default: ;
      endcase
    end
  end

  erm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .echo_width(echo_width),
    .timed_out (timed_out),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  erm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_word(push_word),
    .full     (q_full),
    .pop      (pop),
    .pop_word (pop_word),
    .empty    (q_empty)
  );

  erm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (q_empty),
    .pop_word  (pop_word),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .distance  (distance),
    .held      (held),
    .kept_count(kept_count)
  );

endmodule

// File: sv/erm_checker.sv
module erm_checker
  import erm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [DIST_W-1:0]    distance,
  input logic                 held,
  input logic [CNT_W-1:0]     kept_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance) && $stable(held)
      && $stable(kept_count))
    else $error("stalled result word changed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kept_count <= CNT_W'(GROUP_SIZE))
    else $error("kept count out of range");

  a_empty_group: assert property (@(posedge clk) disable iff (rst)
    out_valid && kept_count == '0 |-> distance == '0 && !held)
    else $error("empty group not reported as zero");

  a_held_needs_samples: assert property (@(posedge clk) disable iff (rst)
    out_valid && held |-> kept_count != '0 && distance != '0)
    else $error("held word without samples or previous distance");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word valid straight after reset");

endmodule

bind echo_range_median_filter erm_checker u_erm_checker (.*);
